@@ design/lss_pkg.sv @@
`timescale 1ns / 1ps

package lss_pkg;

   // Transaction opcodes
   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_PUSH  = 2'd0;
   localparam opcode_type OP_POP   = 2'd1;
   localparam opcode_type OP_CLEAR = 2'd2;

   // Result status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_OVERFLOW  = 2'd1;
   localparam status_type ST_UNDERFLOW = 2'd2;

   // Register map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_CAPACITY  = 2'd0;
   localparam csr_index_type CSR_AUTO_GROW = 2'd1;

   // Fixed field widths
   localparam int LEVEL_OUT_W = 11;
   localparam int COUNT_W     = 32;
   typedef logic [LEVEL_OUT_W-1:0] level_out_type;
   typedef logic [COUNT_W-1:0]     count_type;

   // Capacity policy
   localparam int CAP_RESET   = 16;
   localparam int GROW_MIN    = 8;
   localparam int GROW_FACTOR = 2;

endpackage

@@ design/lss_ram.sv @@
`timescale 1ns / 1ps

module lss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port; read data holds until the next read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/lifo_stack_with_stats.sv @@
`timescale 1ns / 1ps

// LIFO stack with a capacity limit and usage counters. One transaction (push, pop
// or clear) is accepted per clock cycle and its result appears in the output
// register on the next cycle; the block keeps accepting while the result is
// taken in the same cycle, and stalls its input only while a result waits. The
// stack entries live in a single RAM: a push writes the entry at the fill level,
// a pop reads the entry below it through the RAM's registered read port, whose
// output doubles as the popped value of the waiting result. Capacity and
// auto-grow are written through the csr_ port, only in cycles with no accepted
// transaction; a capacity write saturates at DEPTH and clips the fill level to it.
module lifo_stack_with_stats #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // Input transactions
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lss_pkg::opcode_type        req_opcode,
   input  logic signed [DATA_WIDTH-1:0] req_push_value,
   // Results
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_pop_value,
   output lss_pkg::status_type        rsp_status,
   output lss_pkg::level_out_type     rsp_fill_level,
   output lss_pkg::level_out_type     rsp_capacity_now,
   output lss_pkg::count_type         rsp_pushes_done,
   output lss_pkg::count_type         rsp_pops_done,
   output lss_pkg::count_type         rsp_overflows_seen,
   output lss_pkg::count_type         rsp_underflows_seen,
   // Configuration writes
   input  logic                       csr_we,
   input  lss_pkg::csr_index_type     csr_index,
   input  logic [lss_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import lss_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (LVL_W > CSR_DATA_W) ? LVL_W : CSR_DATA_W;
   localparam int CAP_RESET_CLIP = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

   localparam logic [LVL_W-1:0] LVL_DEPTH   = LVL_W'(DEPTH);
   localparam logic [LVL_W-1:0] LVL_CAP_RST = LVL_W'(CAP_RESET_CLIP);
   localparam logic [LVL_W:0]   GROW_LO     = (LVL_W+1)'(GROW_MIN);
   localparam logic [LVL_W:0]   GROW_HI     = (LVL_W+1)'(DEPTH);
   localparam logic [CMP_W-1:0] CMP_DEPTH   = CMP_W'(DEPTH);

   // State registers
   logic [LVL_W-1:0] level_ff, level_in;
   logic [LVL_W-1:0] cap_ff, cap_in;
   logic             grow_ff, grow_in;
   count_type        push_cnt_ff, push_cnt_in;
   count_type        pop_cnt_ff, pop_cnt_in;
   count_type        ovf_cnt_ff, ovf_cnt_in;
   count_type        udf_cnt_ff, udf_cnt_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pop_ff, rsp_pop_in;
   status_type       rsp_status_ff, rsp_status_in;

   // RAM access
   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [DATA_WIDTH-1:0] ram_rdata;

   logic             accept;
   logic [LVL_W:0]   grown;
   logic [LVL_W-1:0] grown_cap;
   logic             room;
   logic [CMP_W-1:0] cfg_cap_wide;
   logic [LVL_W-1:0] cfg_cap;

   // Input stalls only while a finished result is held back
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Auto-grow target: max(2*capacity, minimum), held at DEPTH
   always_comb begin
      grown = {cap_ff, 1'b0};
      if (grown < GROW_LO) begin
         grown = GROW_LO;
      end
      if (grown > GROW_HI) begin
         grown = GROW_HI;
      end
      grown_cap = grown[LVL_W-1:0];
   end

   // Capacity register write, saturated at DEPTH
   always_comb begin
      cfg_cap_wide = CMP_W'(csr_wdata);
      if (cfg_cap_wide > CMP_DEPTH) begin
         cfg_cap_wide = CMP_DEPTH;
      end
      cfg_cap = cfg_cap_wide[LVL_W-1:0];
   end

   // Transaction and configuration update
   always_comb begin
      level_in      = level_ff;
      cap_in        = cap_ff;
      grow_in       = grow_ff;
      push_cnt_in   = push_cnt_ff;
      pop_cnt_in    = pop_cnt_ff;
      ovf_cnt_in    = ovf_cnt_ff;
      udf_cnt_in    = udf_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pop_in    = rsp_pop_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = level_ff[AW-1:0];
      ram_raddr     = AW'(level_ff - LVL_W'(1));
      room          = level_ff < cap_ff;

      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_pop_in    = 1'b0;
         rsp_status_in = ST_OK;
         case (req_opcode)
            OP_PUSH: begin
               if (!room && grow_ff && (grown_cap > level_ff)) begin
                  cap_in = grown_cap;
                  room   = 1'b1;
               end
               if (room && (level_ff < LVL_DEPTH)) begin
                  ram_we      = 1'b1;
                  level_in    = level_ff + LVL_W'(1);
                  push_cnt_in = push_cnt_ff + COUNT_W'(1);
               end else begin
                  ovf_cnt_in    = ovf_cnt_ff + COUNT_W'(1);
                  rsp_status_in = ST_OVERFLOW;
               end
            end
            OP_POP: begin
               if (level_ff == '0) begin
                  udf_cnt_in    = udf_cnt_ff + COUNT_W'(1);
                  rsp_status_in = ST_UNDERFLOW;
               end else begin
                  ram_re     = 1'b1;
                  rsp_pop_in = 1'b1;
                  level_in   = level_ff - LVL_W'(1);
                  pop_cnt_in = pop_cnt_ff + COUNT_W'(1);
               end
            end
            OP_CLEAR: begin
               level_in = '0;
            end
            default: begin
               // undefined opcode: no change, status ok
            end
         endcase
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY: begin
               cap_in = cfg_cap;
               if (level_ff > cfg_cap) begin
                  level_in = cfg_cap;
               end
            end
            CSR_AUTO_GROW: begin
               grow_in = csr_wdata[0];
            end
            default: begin
               // unmapped index: ignored
            end
         endcase
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         cap_ff       <= LVL_CAP_RST;
         grow_ff      <= 1'b0;
         push_cnt_ff  <= '0;
         pop_cnt_ff   <= '0;
         ovf_cnt_ff   <= '0;
         udf_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         cap_ff       <= cap_in;
         grow_ff      <= grow_in;
         push_cnt_ff  <= push_cnt_in;
         pop_cnt_ff   <= pop_cnt_in;
         ovf_cnt_ff   <= ovf_cnt_in;
         udf_cnt_ff   <= udf_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_pop_ff    <= rsp_pop_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Stack store
   lss_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_push_value),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Counters hold the post-transaction values while a result waits, since no new
   // transaction is taken meanwhile; a csr_ write can still change level or capacity
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pop_value       = rsp_pop_ff ? ram_rdata : '0;
   assign rsp_status          = rsp_status_ff;
   assign rsp_fill_level      = LEVEL_OUT_W'(level_ff);
   assign rsp_capacity_now    = LEVEL_OUT_W'(cap_ff);
   assign rsp_pushes_done     = push_cnt_ff;
   assign rsp_pops_done       = pop_cnt_ff;
   assign rsp_overflows_seen  = ovf_cnt_ff;
   assign rsp_underflows_seen = udf_cnt_ff;

endmodule
